### rtl/iwd_pkg.sv
// ----------------------------------------------------------------------------
// iwd_pkg: shared widths, constants and tables for the ISO week date block
// Holds the field widths, reciprocal constants and the month tables.
// ----------------------------------------------------------------------------
package iwd_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int WEEK_W    = 6;
    localparam int WEEKDAY_W = 3;

    localparam int YY_W  = YEAR_W + 1;   // biased year
    localparam int Q100_W = 8;           // year / 100
    localparam int DOY_W = 9;            // day of year, 1..366
    localparam int SUM_W = 15;           // day count before mod 7
    localparam int Q7_W  = 13;           // SUM / 7

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YY_W-1:0]    YEAR_BIAS  = 15'd399;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    // Reciprocal multiply constants: floor(n / 100) and floor(n / 7)
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          SHIFT_100       = 19;
    localparam logic [16:0] RECIP_7         = 17'd74899;
    localparam int          SHIFT_7         = 19;
    localparam logic [8:0]  RECIP_7_SMALL   = 9'd293;
    localparam int          SHIFT_7_SMALL   = 11;

    localparam logic [WEEKDAY_W-1:0] WEDNESDAY = 3'd3;
    localparam logic [WEEKDAY_W-1:0] THURSDAY  = 3'd4;
    localparam logic [WEEKDAY_W-1:0] FRIDAY    = 3'd5;
    localparam logic [WEEKDAY_W-1:0] SATURDAY  = 3'd6;
    localparam logic [WEEKDAY_W-1:0] SUNDAY    = 3'd7;

    localparam logic [WEEK_W-1:0] WEEK_NONE  = 6'd0;
    localparam logic [WEEK_W-1:0] WEEK_FIRST = 6'd1;
    localparam logic [WEEK_W-1:0] WEEK_SHORT = 6'd52;
    localparam logic [WEEK_W-1:0] WEEK_LONG  = 6'd53;

    // Days in all months before the given one (non-leap year)
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // Length of the month in a non-leap year; zero for a month code out of range
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

### rtl/iwd_cal_if.sv
// ----------------------------------------------------------------------------
// iwd_cal_if: calendar date channel
// Carries one Gregorian date word with a valid / ready handshake.
// ----------------------------------------------------------------------------
interface iwd_cal_if;
    import iwd_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;

    modport source (output valid, output cal_year, output cal_month, output cal_day,
                    input ready);
    modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                    output ready);
endinterface

### rtl/iwd_iso_if.sv
// ----------------------------------------------------------------------------
// iwd_iso_if: ISO week date channel
// Carries one ISO week date word with a valid / ready handshake.
// ----------------------------------------------------------------------------
interface iwd_iso_if;
    import iwd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    iso_year;
    logic [WEEK_W-1:0]    iso_week;
    logic [WEEKDAY_W-1:0] iso_weekday;
    logic                 date_invalid;

    modport source (output valid, output iso_year, output iso_week,
                    output iso_weekday, output date_invalid, input ready);
    modport sink   (input valid, input iso_year, input iso_week,
                    input iso_weekday, input date_invalid, output ready);
endinterface

### rtl/iso_week_date_from_calendar_date.sv
// ----------------------------------------------------------------------------
// iso_week_date_from_calendar_date: Gregorian date to ISO 8601 week date
// Throughput 1 word/cycle while the output is not stalled.
// Five register stages with per-stage valid bits; a stall holds each word.
// Reset (rst_n low, async) clears every valid bit; no other state to clear.
// ----------------------------------------------------------------------------
module iso_week_date_from_calendar_date (
    input  logic             clk,
    input  logic             rst_n,
    iwd_cal_if.sink          cal,
    iwd_iso_if.source        iso
);
    import iwd_pkg::*;

    // ------------------------------------------------------------------------
    // Pipeline overview
    //   S1: register the date, form the biased year (y + 399, which has the
    //       same leap rule as y - 1 and keeps January / February counts in
    //       the year before), and divide both years by 100 by reciprocal
    //       multiply.
    //   S2: leap flags, date check, day of year, and the day counts that
    //       give the weekday of January 1 and of the date itself.
    //   S3: divide both day counts by 7 (reciprocal multiply).
    //   S4: remainders to weekdays, raw week = (doy + 10 - weekday) / 7.
    //   S5: fold week 0 into the previous year and week 53 into the next
    //       year where that year is short; zero the fields of a bad date.
    // ------------------------------------------------------------------------

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YY_W-1:0]    yy;
        logic [Q100_W-1:0]  q100_y;
        logic [Q100_W-1:0]  q100_yy;
    } s1_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [DOY_W-1:0]  doy;
        logic [SUM_W-1:0]  sum_jan1;
        logic [SUM_W-1:0]  sum_date;
        logic              leap_y;
        logic              leap_ym1;
        logic              invalid;
    } s2_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [DOY_W-1:0]  doy;
        logic [SUM_W-1:0]  sum_jan1;
        logic [SUM_W-1:0]  sum_date;
        logic [Q7_W-1:0]   q7_jan1;
        logic [Q7_W-1:0]   q7_date;
        logic              leap_y;
        logic              leap_ym1;
        logic              invalid;
    } s3_t;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [WEEK_W-1:0]    week;
        logic [WEEKDAY_W-1:0] weekday;
        logic [WEEKDAY_W-1:0] jan1_wd;
        logic                 leap_y;
        logic                 leap_ym1;
        logic                 invalid;
    } s4_t;

    typedef struct packed {
        logic [YEAR_W-1:0]    iso_year;
        logic [WEEK_W-1:0]    iso_week;
        logic [WEEKDAY_W-1:0] iso_weekday;
        logic                 date_invalid;
    } s5_t;

    localparam int NUM_STAGES = 5;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;
    logic [NUM_STAGES-1:0] vld_in;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    // ------------------------------------------------------------------------
    // Handshake: a stage advances when it is empty or the next one advances.
    // Bubbles collapse, so new words enter while a result waits at the output.
    // ------------------------------------------------------------------------
    assign vld_in = {vld_reg[NUM_STAGES-2:0], cal.valid};

    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || iso.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            vld_next[i] = adv[i] ? vld_in[i] : vld_reg[i];
        end
    end

    assign cal.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------------
    // S1: biased year and the two divisions by 100
    // ------------------------------------------------------------------------
    logic [27:0] prod_100_y;
    logic [27:0] prod_100_yy;

    always_comb
    begin
        s1_next.year    = cal.cal_year;
        s1_next.month   = cal.cal_month;
        s1_next.day     = cal.cal_day;
        s1_next.yy      = YY_W'(cal.cal_year) + YEAR_BIAS;
        prod_100_y      = 28'(cal.cal_year) * 28'(RECIP_100);
        prod_100_yy     = 28'(s1_next.yy) * 28'(RECIP_100);
        s1_next.q100_y  = Q100_W'(prod_100_y >> SHIFT_100);
        s1_next.q100_yy = Q100_W'(prod_100_yy >> SHIFT_100);
    end

    // ------------------------------------------------------------------------
    // S2: leap flags, date check, day of year and the day counts
    // ------------------------------------------------------------------------
    logic [6:0]        r100_y;
    logic [6:0]        r100_yy;
    logic [DAY_W-1:0]  len;
    logic              bad_year;
    logic              bad_month;

    always_comb
    begin
        r100_y  = 7'(YEAR_W'(s1_reg.year) - YEAR_W'(s1_reg.q100_y) * YEAR_W'(100));
        r100_yy = 7'(s1_reg.yy - YY_W'(s1_reg.q100_yy) * YY_W'(100));

        s2_next.year     = s1_reg.year;
        s2_next.leap_y   = (s1_reg.year[1:0] == 2'd0)
                           && (r100_y != 7'd0 || s1_reg.q100_y[1:0] == 2'd0);
        // y + 399 is y - 1 shifted by a whole 400-year cycle
        s2_next.leap_ym1 = (s1_reg.yy[1:0] == 2'd0)
                           && (r100_yy != 7'd0 || s1_reg.q100_yy[1:0] == 2'd0);

        len       = month_len(s1_reg.month)
                    + DAY_W'(s1_reg.month == MONTH_FEB && s2_next.leap_y);
        bad_year  = (s1_reg.year == '0) || (s1_reg.year > YEAR_MAX);
        bad_month = (s1_reg.month < MONTH_JAN) || (s1_reg.month > MONTH_DEC);
        s2_next.invalid = bad_year || bad_month || (s1_reg.day == '0)
                          || (s1_reg.day > len);

        s2_next.doy = days_before(s1_reg.month) + DOY_W'(s1_reg.day)
                      + DOY_W'(s1_reg.month > MONTH_FEB && s2_next.leap_y);

        // Day count of January 1 (mod 7 gives 0 = Sunday .. 6 = Saturday)
        s2_next.sum_jan1 = SUM_W'(s1_reg.yy) + SUM_W'(s1_reg.yy >> 2)
                           - SUM_W'(s1_reg.q100_yy) + SUM_W'(s1_reg.q100_yy >> 2)
                           + SUM_W'(1);
        // Advance by the day of year to reach the date itself
        s2_next.sum_date = s2_next.sum_jan1 + SUM_W'(s2_next.doy) - SUM_W'(1);
    end

    // ------------------------------------------------------------------------
    // S3: divide both day counts by 7
    // ------------------------------------------------------------------------
    logic [31:0] prod_7_jan1;
    logic [31:0] prod_7_date;

    always_comb
    begin
        prod_7_jan1      = 32'(s2_reg.sum_jan1) * 32'(RECIP_7);
        prod_7_date      = 32'(s2_reg.sum_date) * 32'(RECIP_7);
        s3_next.year     = s2_reg.year;
        s3_next.doy      = s2_reg.doy;
        s3_next.sum_jan1 = s2_reg.sum_jan1;
        s3_next.sum_date = s2_reg.sum_date;
        s3_next.q7_jan1  = Q7_W'(prod_7_jan1 >> SHIFT_7);
        s3_next.q7_date  = Q7_W'(prod_7_date >> SHIFT_7);
        s3_next.leap_y   = s2_reg.leap_y;
        s3_next.leap_ym1 = s2_reg.leap_ym1;
        s3_next.invalid  = s2_reg.invalid;
    end

    // ------------------------------------------------------------------------
    // S4: weekdays (Monday = 1 .. Sunday = 7) and the raw week number
    // ------------------------------------------------------------------------
    logic [WEEKDAY_W-1:0] rem_jan1;
    logic [WEEKDAY_W-1:0] rem_date;
    logic [DOY_W-1:0]     week_num;
    logic [17:0]          prod_week;

    always_comb
    begin
        rem_jan1 = WEEKDAY_W'(s3_reg.sum_jan1 - SUM_W'(s3_reg.q7_jan1) * SUM_W'(7));
        rem_date = WEEKDAY_W'(s3_reg.sum_date - SUM_W'(s3_reg.q7_date) * SUM_W'(7));

        // Remainder 0 is Sunday; the rest already match ISO numbering
        s4_next.jan1_wd = (rem_jan1 == '0) ? SUNDAY : rem_jan1;
        s4_next.weekday = (rem_date == '0) ? SUNDAY : rem_date;

        week_num     = s3_reg.doy + DOY_W'(10) - DOY_W'(s4_next.weekday);
        prod_week    = 18'(week_num) * 18'(RECIP_7_SMALL);
        s4_next.week = WEEK_W'(prod_week >> SHIFT_7_SMALL);

        s4_next.year     = s3_reg.year;
        s4_next.leap_y   = s3_reg.leap_y;
        s4_next.leap_ym1 = s3_reg.leap_ym1;
        s4_next.invalid  = s3_reg.invalid;
    end

    // ------------------------------------------------------------------------
    // S5: year wrap-around. A year has 53 weeks when it starts on a Thursday
    // or ends on one. From January 1 of this year:
    //   this year ends Thursday  -> Jan 1 is Thursday, or Wednesday if leap
    //   last year is long        -> Jan 1 is Friday, or Saturday if last
    //                               year was leap
    // ------------------------------------------------------------------------
    logic long_y;
    logic long_ym1;

    always_comb
    begin
        long_y   = (s4_reg.jan1_wd == THURSDAY)
                   || (s4_reg.leap_y && s4_reg.jan1_wd == WEDNESDAY);
        long_ym1 = (s4_reg.jan1_wd == FRIDAY)
                   || (s4_reg.leap_ym1 && s4_reg.jan1_wd == SATURDAY);

        s5_next.iso_year     = s4_reg.year;
        s5_next.iso_week     = s4_reg.week;
        s5_next.iso_weekday  = s4_reg.weekday;
        s5_next.date_invalid = s4_reg.invalid;

        if (s4_reg.invalid)
        begin
            s5_next.iso_year    = '0;
            s5_next.iso_week    = WEEK_NONE;
            s5_next.iso_weekday = '0;
        end
        else if (s4_reg.week == WEEK_NONE)
        begin
            // Early January: last week of the previous year
            s5_next.iso_year = s4_reg.year - YEAR_W'(1);
            s5_next.iso_week = long_ym1 ? WEEK_LONG : WEEK_SHORT;
        end
        else if (s4_reg.week == WEEK_LONG && !long_y)
        begin
            // Late December: first week of the next year
            s5_next.iso_year = s4_reg.year + YEAR_W'(1);
            s5_next.iso_week = WEEK_FIRST;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers: load when the stage advances and takes a valid word
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[0] && vld_in[0])
        begin
            s1_reg <= s1_next;
        end
        if (adv[1] && vld_in[1])
        begin
            s2_reg <= s2_next;
        end
        if (adv[2] && vld_in[2])
        begin
            s3_reg <= s3_next;
        end
        if (adv[3] && vld_in[3])
        begin
            s4_reg <= s4_next;
        end
        if (adv[4] && vld_in[4])
        begin
            s5_reg <= s5_next;
        end
    end

    assign iso.valid        = vld_reg[NUM_STAGES-1];
    assign iso.iso_year     = s5_reg.iso_year;
    assign iso.iso_week     = s5_reg.iso_week;
    assign iso.iso_weekday  = s5_reg.iso_weekday;
    assign iso.date_invalid = s5_reg.date_invalid;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for iso_week_date_from_calendar_date
// Drives calendar dates (invalid ones included) through the date channel and
// checks every ISO week date word against a behavioral predictor, in order.
// Covers random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import iwd_pkg::*;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  DRAIN_CYCLES = 20;     // pipeline is 5 deep; leave slack
    localparam int  REPORT_MAX   = 10;

    // Weekday offset per month (Sakamoto) and days before each month
    localparam int MONTH_OFFSET [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    localparam int DAYS_AHEAD   [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                         304, 334};

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [WEEK_W-1:0]    week;
        logic [WEEKDAY_W-1:0] weekday;
        logic                 invalid;
    } iso_word_t;

    logic clk;
    logic rst_n;

    iwd_cal_if cal_ch ();
    iwd_iso_if iso_ch ();

    iso_week_date_from_calendar_date dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cal   (cal_ch),
        .iso   (iso_ch)
    );

    iso_word_t pending_weeks [$];   // ISO words still owed by the block, oldest first
    int        mismatch_count;
    int        cycle_count;
    bit        idle_enable;         // random idling on both channels
    int        hold_cycles;         // long output hold-off, counted down below

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: calendar date to ISO week date
    // ------------------------------------------------------------------------
    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int y, input int m);
        case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Monday = 1 .. Sunday = 7; the 400-year bias keeps year 0 positive
    function automatic int day_of_week(input int y, input int m, input int d);
        int yy;
        int s;
        yy = y + 400;
        if (m < 3)
            yy = yy - 1;
        s = (yy + yy / 4 - yy / 100 + yy / 400 + MONTH_OFFSET[m - 1] + d) % 7;
        return ((s + 6) % 7) + 1;
    endfunction

    function automatic int ordinal_day(input int y, input int m, input int d);
        int n;
        n = DAYS_AHEAD[m - 1] + d;
        if (m > 2 && leap_year(y))
            n = n + 1;
        return n;
    endfunction

    // Week number of a date whose raw week is at least 1; fold week 53 forward
    // into week 1 of the next year unless the year is a long one
    function automatic void fold_long_week(input int y, input int m, input int d,
                                           output int iso_y, output int iso_w);
        int w;
        w = (ordinal_day(y, m, d) + 10 - day_of_week(y, m, d)) / 7;
        iso_y = y;
        iso_w = w;
        if (w == WEEK_LONG && day_of_week(y, 1, 1) != THURSDAY
            && day_of_week(y, 12, 31) != THURSDAY)
        begin
            iso_y = y + 1;
            iso_w = WEEK_FIRST;
        end
    endfunction

    function automatic iso_word_t iso_date_of(input logic [YEAR_W-1:0] y_in,
                                              input logic [MONTH_W-1:0] m_in,
                                              input logic [DAY_W-1:0] d_in);
        iso_word_t r;
        int y;
        int m;
        int d;
        int wd;
        int w;
        int iso_y;
        int iso_w;
        y = y_in;
        m = m_in;
        d = d_in;
        r = '0;
        if (y < 1 || y > YEAR_MAX || m < 1 || m > 12 || d < 1
            || d > days_in_month(y, m))
        begin
            r.invalid = 1'b1;
            return r;
        end
        wd = day_of_week(y, m, d);
        w  = (ordinal_day(y, m, d) + 10 - wd) / 7;
        // Week 0 belongs to the last week of the previous year
        if (w == 0)
            fold_long_week(y - 1, 12, 28, iso_y, iso_w);
        else
            fold_long_week(y, m, d, iso_y, iso_w);
        r.year    = iso_y[YEAR_W-1:0];
        r.week    = iso_w[WEEK_W-1:0];
        r.weekday = wd[WEEKDAY_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: ready with random stall bursts, plus the long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        iso_ch.ready = 1'b0;
        hold_cycles  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                // Hold off until the count runs out; the pipe fills and stalls input
                iso_ch.ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                iso_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
            begin
                iso_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each accepted word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_words
        iso_word_t want;
        iso_word_t got;
        if (rst_n && iso_ch.valid && iso_ch.ready)
        begin
            got = '{iso_ch.iso_year, iso_ch.iso_week, iso_ch.iso_weekday,
                    iso_ch.date_invalid};
            if (pending_weeks.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_MAX)
                    $display("[%0t] unexpected word: year %0d week %0d day %0d inv %0b",
                             $realtime, got.year, got.week, got.weekday, got.invalid);
            end
            else
            begin
                want = pending_weeks.pop_front();
                if (got.year !== want.year || got.week !== want.week
                    || got.weekday !== want.weekday || got.invalid !== want.invalid)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $write("[%0t] mismatch: expected year %0d week %0d day %0d inv %0b, ",
                               $realtime, want.year, want.week, want.weekday,
                               want.invalid);
                        $display("got year %0d week %0d day %0d inv %0b",
                                 got.year, got.week, got.weekday, got.invalid);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Send one date word; optionally idle first, then wait for acceptance
    // ------------------------------------------------------------------------
    task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d);
        int gap;
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            cal_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cal_ch.valid     <= 1'b1;
        cal_ch.cal_year  <= y;
        cal_ch.cal_month <= m;
        cal_ch.cal_day   <= d;
        do
            @(posedge clk);
        while (!(cal_ch.valid && cal_ch.ready));
        pending_weeks.push_back(iso_date_of(y, m, d));
    endtask

    // Random real date, random real date near a year turn, broken date, or noise
    task automatic send_random_date();
        int y;
        int m;
        int d;
        int pick;
        pick = $urandom_range(0, 99);
        y = $urandom_range(1, YEAR_MAX);
        if (pick < 55)
        begin
            m = $urandom_range(1, 12);
            d = $urandom_range(1, days_in_month(y, m));
        end
        else if (pick < 80)
        begin
            // Year turn: late December or early January, where weeks roll over
            if ($urandom_range(0, 1))
            begin
                m = 12;
                d = $urandom_range(22, 31);
            end
            else
            begin
                m = 1;
                d = $urandom_range(1, 10);
            end
            if ($urandom_range(0, 9) == 0)
                y = $urandom_range(0, 1) ? 1 : YEAR_MAX;
        end
        else if (pick < 92)
        begin
            // Broken: day past the month end, bad month, day 0 or bad year
            m = $urandom_range(1, 12);
            d = $urandom_range(1, 28);
            case ($urandom_range(0, 3))
                0: if (days_in_month(y, m) < 31)
                       d = $urandom_range(days_in_month(y, m) + 1, 31);
                   else
                       d = 0;
                1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
                2: d = 0;
                default: y = $urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383);
            endcase
        end
        else
        begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        send_date(y[YEAR_W-1:0], m[MONTH_W-1:0], d[DAY_W-1:0]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes and every way a date can be invalid
    task automatic test_invalid_dates();
        send_date(14'd0,      4'd1,  5'd1);     // year 0
        send_date(14'd10000,  4'd1,  5'd1);     // just past the top year
        send_date(14'h3FFF,   4'hF,  5'h1F);    // all ones
        send_date(14'd2024,   4'd0,  5'd10);    // month 0
        send_date(14'd2024,   4'd13, 5'd10);    // month just past December
        send_date(14'd2024,   4'd5,  5'd0);     // day 0
        send_date(14'd2023,   4'd4,  5'd31);    // 31st of a 30-day month
        send_date(14'd1,      4'd1,  5'd1);     // first day of the range
        send_date(14'd9999,   4'd12, 5'd31);    // last day of the range
    endtask

    // Leap day rules: every 4th, not every 100th, every 400th
    task automatic test_leap_days();
        send_date(14'd2000, MONTH_FEB, 5'd29);
        send_date(14'd1900, MONTH_FEB, 5'd29);  // century, not leap
        send_date(14'd2004, MONTH_FEB, 5'd29);
        send_date(14'd2001, MONTH_FEB, 5'd29);
        send_date(14'd2004, MONTH_DEC, 5'd31);  // day 366
    endtask

    // Dates whose ISO year differs from the calendar year, and long years
    task automatic test_year_boundaries();
        send_date(14'd2008, MONTH_DEC, 5'd29);  // Monday, week 1 of next year
        send_date(14'd2010, MONTH_JAN, 5'd1);   // Friday, week 53 of last year
        send_date(14'd2005, MONTH_JAN, 5'd1);   // Saturday, week 53 of last year
        send_date(14'd2006, MONTH_JAN, 5'd1);   // Sunday, week 52 of last year
        send_date(14'd2020, MONTH_DEC, 5'd31);  // Thursday, long year
        send_date(14'd2015, MONTH_DEC, 5'd31);  // Thursday on January 1
        send_date(14'd2019, MONTH_DEC, 5'd30);  // Monday, rolls forward
        send_date(14'd2,    MONTH_JAN, 5'd1);   // early January near the bottom
        send_date(14'd9999, MONTH_DEC, 5'd27);
        send_date(14'd1,    MONTH_DEC, 5'd31);
    endtask

    // Hold the output off for a long stretch while dates keep coming
    task automatic test_output_hold();
        hold_cycles = 300;
        repeat (40) send_random_date();
    endtask

    // Bulk random dates; idling switched per block, none in the last part
    task automatic test_random_dates();
        for (int blk = 0; blk < 9; blk++)
        begin
            idle_enable = (blk == 2) ? 1'b0 : 1'b1;
            repeat (150) send_random_date();
        end
        idle_enable = 1'b0;
        repeat (450) send_random_date();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cal_ch.valid     = 1'b0;
        cal_ch.cal_year  = '0;
        cal_ch.cal_month = '0;
        cal_ch.cal_day   = '0;
        idle_enable      = 1'b1;
        mismatch_count   = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_invalid_dates();
        test_leap_days();
        test_year_boundaries();
        test_output_hold();
        test_random_dates();

        @(negedge clk);
        cal_ch.valid <= 1'b0;
        // Drain, then give any stray word time to show up
        while (pending_weeks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_weeks.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/iwd_pkg.sv
rtl/iwd_cal_if.sv
rtl/iwd_iso_if.sv
rtl/iso_week_date_from_calendar_date.sv
bench/tb.sv
